/* rtl/core/gf2alu_pkg.sv */
// ----------------------------------------------------------------------------
// GF(2) polynomial ALU package
// Shared types and codes for the polynomial ALU: item payloads, opcodes and
// the control word of the shift-XOR unit.
// ----------------------------------------------------------------------------
package gf2alu_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned OPERAND_W = 32;
  localparam int unsigned RES_W     = 63;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_MUL = 3'd1;
  localparam logic [OP_W-1:0] OP_QUO = 3'd2;
  localparam logic [OP_W-1:0] OP_REM = 3'd3;
  localparam logic [OP_W-1:0] OP_IRR = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [OPERAND_W-1:0] operand_a;
    logic [OPERAND_W-1:0] operand_b;
  } gf2alu_in_t;

  typedef struct packed {
    logic [RES_W-1:0] poly_result;
    logic             is_irreducible;
    logic             divide_by_zero;
  } gf2alu_out_t;

  // Control word of the shared shift-XOR unit.
  typedef struct packed {
    logic in_bit;  // bit shifted into the low end of the accumulator
    logic add_en;  // XOR the addend after the shift
    logic red_en;  // reduce by the modulus when its leading position is set
  } gf2alu_shx_ctrl_t;

endpackage

/* rtl/core/gf2alu_shx.sv */
// ----------------------------------------------------------------------------
// GF(2) shift-XOR step
// One step of carry-less multiplication, long division or interleaved
// modular multiplication: shift, optional add, optional reduction.
// ----------------------------------------------------------------------------
module gf2alu_shx import gf2alu_pkg::*; #(
  parameter int unsigned W = 32,
  localparam int unsigned AW = 2 * W - 1,
  localparam int unsigned DW = $clog2(W)
) (
  input  gf2alu_shx_ctrl_t ctrl_i,
  input  logic [AW-1:0]    acc_i,
  input  logic [W-1:0]     add_val_i,
  input  logic [W-1:0]     red_val_i,
  input  logic [DW-1:0]    red_pos_i,
  output logic [AW-1:0]    acc_o,
  output logic             hit_o
);

  logic [AW-1:0] shifted;
  logic [AW-1:0] summed;
  logic [W-1:0]  low;

  assign shifted = {acc_i[AW-2:0], ctrl_i.in_bit};
  assign summed  = shifted ^ (ctrl_i.add_en ? AW'(add_val_i) : '0);
  assign low     = summed[W-1:0];

  // The leading term of the modulus is cancelled with a single XOR, which
  // is also the quotient bit during long division.
  assign hit_o = ctrl_i.red_en & low[red_pos_i];
  assign acc_o = hit_o ? (summed ^ AW'(red_val_i)) : summed;

endmodule

/* rtl/core/gf2_polynomial_alu_unit.sv */
// ----------------------------------------------------------------------------
// GF(2) polynomial ALU
// Add, carry-less multiply, divide, remainder and irreducibility test of
// polynomials over GF(2) on one shared shift-XOR unit.
// ----------------------------------------------------------------------------
// Polynomials are packed with bit i holding the coefficient of x^i; operand
// bits above MAX_DEGREE are ignored. The unit takes one item at a time and
// keeps in_ready_o low until that item's result sits in the output register,
// which then waits for out_ready_i while the next item is already taken in.
// Add, unknown opcodes and division by zero go straight to S_FIN;
// multiply forms one partial product per cycle; quotient and remainder
// first scan the divisor for its degree, then run long division, one
// dividend bit per cycle. The irreducibility test of a polynomial of
// degree n first scans for n, then runs n/2 rounds, each one squaring of h
// modulo a followed by a binary gcd of a and h + x; it stops at the first
// round that finds a common factor. All multiply, divide and squaring steps
// go through the single shift-XOR unit; the gcd steps use one XOR, one shift
// and one magnitude compare per cycle. Division by zero gives a zero result
// with divide_by_zero set, zero is reported reducible and polynomials of
// degree 0 or 1 irreducible.
// ----------------------------------------------------------------------------
module gf2_polynomial_alu_unit import gf2alu_pkg::*; #(
  parameter int unsigned MAX_DEGREE = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  gf2alu_in_t  in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output gf2alu_out_t out_o
);

  localparam int unsigned W  = MAX_DEGREE + 1;
  localparam int unsigned AW = 2 * W - 1;
  localparam int unsigned DW = $clog2(W);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;  // degree scan of divisor or modulus
  localparam logic [2:0] S_DIV  = 3'd2;  // long division, one bit per cycle
  localparam logic [2:0] S_MUL  = 3'd3;  // carry-less multiply
  localparam logic [2:0] S_SQR  = 3'd4;  // h = h * h mod a
  localparam logic [2:0] S_GCD  = 3'd5;  // binary gcd of a and h + x
  localparam logic [2:0] S_FIN  = 3'd6;  // result ready for the output register

  logic [2:0]        state_q, state_d;
  logic              out_valid_q, out_valid_d;
  gf2alu_out_t       out_q, out_d;

  logic [OP_W-1:0]   op_q, op_d;
  logic [W-1:0]      a_q, a_d;
  logic [W-1:0]      b_q, b_d;
  logic [W-1:0]      scan_q, scan_d;
  logic [DW-1:0]     deg_q, deg_d;
  logic [DW-1:0]     cnt_q, cnt_d;
  logic [DW-1:0]     iter_q, iter_d;
  logic [AW-1:0]     acc_q, acc_d;
  logic [W-1:0]      quo_q, quo_d;
  logic [W-1:0]      h_q, h_d;
  logic [W-1:0]      u_q, u_d;
  logic [W-1:0]      v_q, v_d;
  logic [AW-1:0]     res_q, res_d;
  logic              irr_q, irr_d;
  logic              dz_q, dz_d;

  gf2alu_shx_ctrl_t  shx_ctrl;
  logic [W-1:0]      shx_add;
  logic [W-1:0]      shx_red;
  logic [AW-1:0]     shx_acc;
  logic              shx_hit;

  logic [W-1:0]      in_a;
  logic [W-1:0]      in_b;
  logic [W-1:0]      sqr_g;
  logic [W-1:0]      quo_next;

  assign in_a = in_i.operand_a[W-1:0];
  assign in_b = in_i.operand_b[W-1:0];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The shared unit: its operands are chosen by the current state.
  always_comb begin
    shx_ctrl = '0;
    shx_add  = a_q;
    shx_red  = b_q;
    case (state_q)
      S_DIV: begin
        shx_ctrl.in_bit = a_q[cnt_q];
        shx_ctrl.red_en = 1'b1;
      end
      S_MUL: begin
        shx_ctrl.add_en = b_q[cnt_q];
      end
      S_SQR: begin
        shx_ctrl.add_en = h_q[cnt_q];
        shx_ctrl.red_en = 1'b1;
        shx_add         = h_q;
        shx_red         = a_q;
      end
      default: begin
        shx_ctrl = '0;
      end
    endcase
  end

  gf2alu_shx #(
    .W(W)
  ) u_shx (
    .ctrl_i   (shx_ctrl),
    .acc_i    (acc_q),
    .add_val_i(shx_add),
    .red_val_i(shx_red),
    .red_pos_i(deg_q),
    .acc_o    (shx_acc),
    .hit_o    (shx_hit)
  );

  assign quo_next = {quo_q[W-2:0], shx_hit};
  // Squared value plus x, the second gcd operand of this round.
  assign sqr_g    = shx_acc[W-1:0] ^ W'(2);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    scan_d      = scan_q;
    deg_d       = deg_q;
    cnt_d       = cnt_q;
    iter_d      = iter_q;
    acc_d       = acc_q;
    quo_d       = quo_q;
    h_d         = h_q;
    u_d         = u_q;
    v_d         = v_q;
    res_d       = res_q;
    irr_d       = irr_q;
    dz_d        = dz_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = in_i.op;
          a_d    = in_a;
          b_d    = in_b;
          res_d  = '0;
          irr_d  = 1'b0;
          dz_d   = 1'b0;
          scan_d = (in_i.op == OP_IRR) ? in_a : in_b;
          deg_d  = DW'(W - 1);
          acc_d  = '0;
          quo_d  = '0;
          cnt_d  = DW'(W - 1);
          case (in_i.op)
            OP_ADD: begin
              res_d   = AW'(in_a ^ in_b);
              state_d = S_FIN;
            end
            OP_MUL: begin
              state_d = S_MUL;
            end
            OP_QUO, OP_REM: begin
              if (in_b == '0) begin
                dz_d    = 1'b1;
                state_d = S_FIN;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_IRR: begin
              state_d = (in_a == '0) ? S_FIN : S_SCAN;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_q[W-1]) begin
          if (op_q == OP_IRR) begin
            if ({1'b0, deg_q} < (DW + 1)'(2)) begin
              irr_d   = 1'b1;
              state_d = S_FIN;
            end else begin
              iter_d  = deg_q >> 1;
              h_d     = W'(2);
              acc_d   = '0;
              cnt_d   = DW'(W - 1);
              state_d = S_SQR;
            end
          end else begin
            acc_d   = '0;
            quo_d   = '0;
            cnt_d   = DW'(W - 1);
            state_d = S_DIV;
          end
        end else begin
          scan_d = scan_q << 1;
          deg_d  = deg_q - DW'(1);
        end
      end

      S_DIV: begin
        acc_d = shx_acc;
        quo_d = quo_next;
        cnt_d = cnt_q - DW'(1);
        if (cnt_q == '0) begin
          res_d   = (op_q == OP_QUO) ? AW'(quo_next) : AW'(shx_acc[W-1:0]);
          state_d = S_FIN;
        end
      end

      S_MUL: begin
        acc_d = shx_acc;
        cnt_d = cnt_q - DW'(1);
        if (cnt_q == '0) begin
          res_d   = shx_acc;
          state_d = S_FIN;
        end
      end

      S_SQR: begin
        acc_d = shx_acc;
        cnt_d = cnt_q - DW'(1);
        if (cnt_q == '0) begin
          h_d = shx_acc[W-1:0];
          // A shared factor x already means a common divisor.
          if (!a_q[0] && !sqr_g[0]) begin
            state_d = S_FIN;
          end else begin
            // Keep u odd so that x never needs to be stripped from it.
            if (a_q[0]) begin
              u_d = a_q;
              v_d = sqr_g;
            end else begin
              u_d = sqr_g;
              v_d = a_q;
            end
            state_d = S_GCD;
          end
        end
      end

      S_GCD: begin
        if (v_q == '0) begin
          if (u_q != W'(1)) begin
            state_d = S_FIN;
          end else if (iter_q == DW'(1)) begin
            irr_d   = 1'b1;
            state_d = S_FIN;
          end else begin
            iter_d  = iter_q - DW'(1);
            acc_d   = '0;
            cnt_d   = DW'(W - 1);
            state_d = S_SQR;
          end
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (v_q >= u_q) begin
          v_d = v_q ^ u_q;
        end else begin
          u_d = v_q;
          v_d = u_q ^ v_q;
        end
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.poly_result    = RES_W'(res_q);
          out_d.is_irreducible = irr_q;
          out_d.divide_by_zero = dz_q;
          out_valid_d          = 1'b1;
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    op_q   <= op_d;
    a_q    <= a_d;
    b_q    <= b_d;
    scan_q <= scan_d;
    deg_q  <= deg_d;
    cnt_q  <= cnt_d;
    iter_q <= iter_d;
    acc_q  <= acc_d;
    quo_q  <= quo_d;
    h_q    <= h_d;
    u_q    <= u_d;
    v_q    <= v_d;
    res_q  <= res_d;
    irr_q  <= irr_d;
    dz_q   <= dz_d;
  end

  // The gcd loop relies on u staying odd.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GCD) |-> u_q[0])
    else $error("gcd operand u lost its constant term");

  // One item at a time: an accepted item closes the input at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still open after an item was accepted");

  // An irreducible verdict never carries a polynomial or a divide error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.is_irreducible) |->
      (out_o.poly_result == '0 && !out_o.divide_by_zero))
    else $error("irreducibility result mixed with other fields");

  // The output register is only loaded when its slot is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_o)))
    else $error("pending result overwritten");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GF(2) polynomial ALU testbench
// Drives add, carry-less multiply, quotient, remainder, irreducibility test
// and reserved opcodes through the valid/ready item channels, with bursty
// input traffic and a patterned output stall, and checks every result item
// against an independent polynomial predictor or a hand-written result.
// ----------------------------------------------------------------------------
module testbench;
  import gf2alu_pkg::*;

  // Opcodes the unit does not define; they must produce an all-zero result.
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 525;
  // The slowest item is a test of an irreducible polynomial of degree 31:
  // a degree scan plus 15 rounds of squaring and gcd. The watchdog allows
  // several times that item's run with no item moving.
  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned REPORT_MAX   = 10;

  typedef logic [63:0] poly64_t;

  // One expected result item together with the input item that caused it.
  typedef struct {
    gf2alu_in_t  item;
    gf2alu_out_t result;
  } expected_entry_t;

  // A row of the directed table; typed_ok selects the hand-written result.
  typedef struct {
    gf2alu_in_t  item;
    logic        typed_ok;
    gf2alu_out_t typed_result;
  } directed_row_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_EVERY_4TH,
    READY_SPARSE
  } ready_pattern_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  gf2alu_in_t  in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  gf2alu_out_t out_o;

  expected_entry_t pending_results[$];
  directed_row_t   directed_rows[$];
  int unsigned     fail_count = 0;
  int unsigned     burst_left = 0;
  int unsigned     idle_cycles = 0;

  ready_pattern_e  ready_pattern = READY_ALWAYS;
  int unsigned     pattern_left = 0;
  logic [1:0]      ready_tick = '0;

  always #5 clk_i = ~clk_i;

  gf2_polynomial_alu_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // --------------------------------------------------------------------------
  // Polynomial predictor. Bit i of a word is the coefficient of x^i; all
  // arithmetic is done on 64-bit words so that products never overflow.
  // --------------------------------------------------------------------------

  // Degree of v; zero and the constant 1 both report degree 0.
  function automatic int unsigned poly_degree(poly64_t v);
    int unsigned d;
    d = 0;
    for (int i = 1; i < 64; i++)
      if (v[i]) d = i;
    return d;
  endfunction

  // Schoolbook long division; the divisor must be nonzero.
  function automatic poly64_t poly_long_div(poly64_t dividend, poly64_t divisor,
                                            output poly64_t remainder);
    poly64_t     quot;
    int unsigned divisor_deg;
    int unsigned shift;
    quot = '0;
    divisor_deg = poly_degree(divisor);
    while (dividend != 0 && poly_degree(dividend) >= divisor_deg) begin
      shift = poly_degree(dividend) - divisor_deg;
      quot[shift] = 1'b1;
      dividend ^= divisor << shift;
    end
    remainder = dividend;
    return quot;
  endfunction

  // Carry-less product; only the low OPERAND_W bits of b take part.
  function automatic poly64_t poly_clmul(poly64_t a, poly64_t b);
    poly64_t prod;
    prod = '0;
    for (int i = 0; i < OPERAND_W; i++)
      if (b[i]) prod ^= a << i;
    return prod;
  endfunction

  function automatic poly64_t poly_reduce(poly64_t a, poly64_t m);
    poly64_t rem;
    void'(poly_long_div(a, m, rem));
    return rem;
  endfunction

  function automatic poly64_t poly_gcd(poly64_t a, poly64_t b);
    poly64_t t;
    while (b != 0) begin
      t = poly_reduce(a, b);
      a = b;
      b = t;
    end
    return a;
  endfunction

  // A polynomial of degree n is irreducible when gcd(a, x^(2^i) + x mod a)
  // is 1 for every i up to n/2. Zero is reducible; degree 0 and 1 pass.
  function automatic logic poly_is_irreducible(poly64_t a);
    poly64_t     h;
    int unsigned n;
    if (a == 0) return 1'b0;
    n = poly_degree(a);
    h = 64'd2;
    for (int unsigned i = 1; i <= n / 2; i++) begin
      h = poly_reduce(poly_clmul(h, h), a);
      if (poly_gcd(a, h ^ 64'd2) != 64'd1) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expected result item for one input item.
  function automatic gf2alu_out_t compute_alu_result(gf2alu_in_t item);
    gf2alu_out_t r;
    poly64_t     a;
    poly64_t     b;
    poly64_t     quot;
    poly64_t     rem;
    r = '0;
    a = 64'(item.operand_a);
    b = 64'(item.operand_b);
    case (item.op)
      OP_ADD: begin
        r.poly_result = RES_W'(a ^ b);
      end
      OP_MUL: begin
        r.poly_result = RES_W'(poly_clmul(a, b));
      end
      OP_QUO, OP_REM: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          quot = poly_long_div(a, b, rem);
          r.poly_result = (item.op == OP_QUO) ? RES_W'(quot) : RES_W'(rem);
        end
      end
      OP_IRR: begin
        r.is_irreducible = poly_is_irreducible(a);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Random polynomial whose degree is drawn from 0 .. top_deg.
  function automatic logic [OPERAND_W-1:0] random_poly(int unsigned top_deg);
    int unsigned          d;
    logic [OPERAND_W-1:0] v;
    d = $urandom_range(0, top_deg);
    v = $urandom();
    v &= (32'h1 << d) - 32'h1;
    v |= 32'h1 << d;
    return v;
  endfunction

  // Operand mix: raw words, random degrees, low degrees and the odd zero.
  function automatic logic [OPERAND_W-1:0] random_operand();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return $urandom();
    if (sel < 80) return random_poly(31);
    if (sel < 97) return random_poly(6);
    return '0;
  endfunction

  function automatic gf2alu_in_t random_item();
    gf2alu_in_t  item;
    int unsigned sel;
    int unsigned shape;
    sel = $urandom_range(0, 99);
    item.operand_a = random_operand();
    item.operand_b = random_operand();
    if (sel < 15) begin
      item.op = OP_ADD;
    end else if (sel < 33) begin
      item.op = OP_MUL;
    end else if (sel < 53) begin
      item.op = OP_QUO;
    end else if (sel < 73) begin
      item.op = OP_REM;
    end else if (sel < 95) begin
      item.op = OP_IRR;
      // Candidates that get past the cheap early rounds: odd polynomials with
      // no factor x and products of two mid-size factors; also low degrees and raw words.
      shape = $urandom_range(0, 9);
      if (shape < 4)
        item.operand_a = random_poly(31) | 32'h1;
      else if (shape < 7)
        item.operand_a = OPERAND_W'(poly_clmul(64'(random_poly(15)),
                                               64'(random_poly(15))));
      else if (shape < 9)
        item.operand_a = random_poly(12);
      else
        item.operand_a = $urandom();
    end else begin
      item.op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
    end
    // Give the zero divisor a fair share of the division traffic.
    if ((item.op == OP_QUO || item.op == OP_REM) && $urandom_range(0, 19) == 0)
      item.operand_b = '0;
    return item;
  endfunction

  task automatic add_row(logic [OP_W-1:0] op, logic [OPERAND_W-1:0] a,
                         logic [OPERAND_W-1:0] b, logic typed_ok,
                         logic [RES_W-1:0] res, logic irr, logic dz);
    directed_row_t row;
    row.item.op              = op;
    row.item.operand_a       = a;
    row.item.operand_b       = b;
    row.typed_ok             = typed_ok;
    row.typed_result.poly_result    = res;
    row.typed_result.is_irreducible = irr;
    row.typed_result.divide_by_zero = dz;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Presents one item and waits for its acceptance. The sender works in
  // bursts: when a burst runs out it drops valid for a random gap, which is
  // sometimes long, and then starts a burst of random length.
  task automatic send_item(gf2alu_in_t item, logic typed_ok, gf2alu_out_t typed);
    expected_entry_t entry;
    int unsigned     gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    entry.item   = item;
    entry.result = typed_ok ? typed : compute_alu_result(item);
    pending_results.insert(pending_results.size(), entry);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random items, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin
    gf2alu_out_t none;
    none = '0;

    // Sums: extremes cancel and pass through unchanged.
    add_row(OP_ADD, 32'h0000_0000, 32'h0000_0000, 1'b1, '0, 1'b0, 1'b0);
    add_row(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '0, 1'b0, 1'b0);
    add_row(OP_ADD, 32'hffff_ffff, 32'h0000_0000, 1'b1, 63'hffff_ffff, 1'b0, 1'b0);
    // Products: widest result, zero, one, and the single top coefficient.
    add_row(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0, 1'b0, 1'b0);
    add_row(OP_MUL, 32'h0000_0000, 32'hffff_ffff, 1'b1, '0, 1'b0, 1'b0);
    add_row(OP_MUL, 32'h0000_0001, 32'h8000_0000, 1'b1, 63'h8000_0000, 1'b0, 1'b0);
    add_row(OP_MUL, 32'h8000_0000, 32'h8000_0000, 1'b1, 63'h1 << 62, 1'b0, 1'b0);
    // Division by zero gives a zero result and the error flag.
    add_row(OP_QUO, 32'h1234_5678, 32'h0000_0000, 1'b1, '0, 1'b0, 1'b1);
    add_row(OP_REM, 32'hffff_ffff, 32'h0000_0000, 1'b1, '0, 1'b0, 1'b1);
    add_row(OP_QUO, 32'h0000_0000, 32'h0000_0000, 1'b1, '0, 1'b0, 1'b1);
    // Division by one, by a larger divisor, by itself, and by 0x11b.
    add_row(OP_QUO, 32'hffff_ffff, 32'h0000_0001, 1'b1, 63'hffff_ffff, 1'b0, 1'b0);
    add_row(OP_REM, 32'hffff_ffff, 32'h0000_0001, 1'b1, '0, 1'b0, 1'b0);
    add_row(OP_QUO, 32'h0000_0005, 32'hffff_ffff, 1'b1, '0, 1'b0, 1'b0);
    add_row(OP_REM, 32'h0000_0005, 32'hffff_ffff, 1'b1, 63'h5, 1'b0, 1'b0);
    add_row(OP_QUO, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 63'h1, 1'b0, 1'b0);
    add_row(OP_QUO, 32'hdead_beef, 32'h0000_011b, 1'b0, '0, 1'b0, 1'b0);
    add_row(OP_REM, 32'hdead_beef, 32'h0000_011b, 1'b0, '0, 1'b0, 1'b0);
    // Irreducibility: zero is reducible, constants and linears pass.
    add_row(OP_IRR, 32'h0000_0000, 32'hffff_ffff, 1'b1, '0, 1'b0, 1'b0);
    add_row(OP_IRR, 32'h0000_0001, 32'h0000_0000, 1'b1, '0, 1'b1, 1'b0);
    add_row(OP_IRR, 32'h0000_0002, 32'h0000_0000, 1'b1, '0, 1'b1, 1'b0);
    add_row(OP_IRR, 32'h0000_0003, 32'h0000_0000, 1'b1, '0, 1'b1, 1'b0);
    // Longest test: a degree-31 trinomial, then an all-ones word.
    add_row(OP_IRR, 32'h8000_0009, 32'h0000_0000, 1'b0, '0, 1'b0, 1'b0);
    add_row(OP_IRR, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0, 1'b0, 1'b0);
    // Reserved opcodes return all zeros whatever the operands.
    add_row(OP_RSVD5, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '0, 1'b0, 1'b0);
    add_row(OP_RSVD6, 32'hffff_ffff, 32'h0000_0000, 1'b1, '0, 1'b0, 1'b0);
    add_row(OP_RSVD7, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '0, 1'b0, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed_ok,
                directed_rows[i].typed_result);
    for (int n = 0; n < RANDOM_ITEMS; n++)
      send_item(random_item(), 1'b0, none);
    in_valid_i <= 1'b0;

    // Wait for the last result item; the watchdog catches a hang here.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: out_ready_i follows a pattern that is redrawn at random
  // intervals, from always ready through coin flips to long stretches of stall.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (pattern_left == 0) begin
      ready_pattern <= ready_pattern_e'($urandom_range(0, 3));
      pattern_left  <= $urandom_range(20, 300);
    end else begin
      pattern_left <= pattern_left - 1;
    end
    ready_tick <= ready_tick + 2'd1;
    case (ready_pattern)
      READY_ALWAYS:    out_ready_i <= 1'b1;
      READY_COIN:      out_ready_i <= ($urandom_range(0, 1) == 1);
      READY_EVERY_4TH: out_ready_i <= (ready_tick == 2'd0);
      default:         out_ready_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Result checker: each accepted result item is compared, field by field,
  // with the oldest expectation. Only the first REPORT_MAX failures are printed.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    expected_entry_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("%0t: result item with nothing expected: poly %h irr %b dz %b",
                   $realtime, out_o.poly_result, out_o.is_irreducible,
                   out_o.divide_by_zero);
      end else begin
        e = pending_results.pop_front();
        if (out_o.poly_result !== e.result.poly_result ||
            out_o.is_irreducible !== e.result.is_irreducible ||
            out_o.divide_by_zero !== e.result.divide_by_zero) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display({"%0t: op %0d a %h b %h: expected poly %h irr %b dz %b,",
                      " got poly %h irr %b dz %b"},
                     $realtime, e.item.op, e.item.operand_a, e.item.operand_b,
                     e.result.poly_result, e.result.is_irreducible,
                     e.result.divide_by_zero, out_o.poly_result,
                     out_o.is_irreducible, out_o.divide_by_zero);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles in which no item moves on either channel.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* sim.f */
rtl/core/gf2alu_pkg.sv
rtl/core/gf2alu_shx.sv
rtl/core/gf2_polynomial_alu_unit.sv
tb/testbench.sv
